@@ rtl/cpcc_pkg.sv @@
// Package: shared types, constants and denomination table for the change controller.
package cpcc_pkg;

  localparam int unsigned CountBits  = 16;
  localparam int unsigned NumDen     = 10;
  localparam int unsigned IdxBits    = 4;
  localparam int unsigned DenBits    = 13;
  localparam int unsigned PaidBits   = 17;
  // Change owed is always below the largest note, so 13 bits carry it
  localparam int unsigned LeftBits   = 13;
  localparam int unsigned RecipBits  = 24;
  localparam int unsigned RecipShift = 26;
  localparam int unsigned QuotBits   = LeftBits + RecipBits - RecipShift;
  localparam logic [CountBits-1:0] CountMax = '1;

  // Request function codes
  localparam logic [1:0] FuncLoad   = 2'd0;
  localparam logic [1:0] FuncBegin  = 2'd1;
  localparam logic [1:0] FuncInsert = 2'd2;
  localparam logic [1:0] FuncCancel = 2'd3;

  // Result status codes
  localparam logic [2:0] StNeedMore   = 3'd0;
  localparam logic [2:0] StInvalid    = 3'd1;
  localparam logic [2:0] StChange     = 3'd2;
  localparam logic [2:0] StSaleDone   = 3'd3;
  localparam logic [2:0] StRefund     = 3'd4;
  localparam logic [2:0] StRefundDone = 3'd5;
  localparam logic [2:0] StIgnored    = 3'd6;
  localparam logic [2:0] StLoaded     = 3'd7;

  // Datapath command codes
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdBegin,
    CmdInsert,
    CmdChgDiv,
    CmdChgTake,
    CmdChgUndo,
    CmdRefStep,
    CmdClose
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [IdxBits-1:0] idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic                 open;
    logic                 den_ok;
    logic                 count_full;
    logic                 paid_ge;
    logic                 left_zero;
    logic                 used_nz;
    logic                 dep_nz;
  } dp_stat_t;

  function automatic logic [DenBits-1:0] den_value(input logic [IdxBits-1:0] i);
    logic [DenBits-1:0] v;
    begin
      unique case (i)
        4'd0: v = 13'd5000;
        4'd1: v = 13'd2000;
        4'd2: v = 13'd1000;
        4'd3: v = 13'd500;
        4'd4: v = 13'd200;
        4'd5: v = 13'd100;
        4'd6: v = 13'd50;
        4'd7: v = 13'd20;
        4'd8: v = 13'd10;
        4'd9: v = 13'd5;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // ceil(2^26 / denomination): exact quotient for any 13-bit amount
  function automatic logic [RecipBits-1:0] recip_value(input logic [IdxBits-1:0] i);
    logic [RecipBits-1:0] v;
    begin
      unique case (i)
        4'd0: v = 24'd13422;
        4'd1: v = 24'd33555;
        4'd2: v = 24'd67109;
        4'd3: v = 24'd134218;
        4'd4: v = 24'd335545;
        4'd5: v = 24'd671089;
        4'd6: v = 24'd1342178;
        4'd7: v = 24'd3355444;
        4'd8: v = 24'd6710887;
        4'd9: v = 24'd13421773;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ rtl/cpcc_datapath.sv @@
// Datapath: stock and deposit counts, paid/price registers, greedy change stage.
module cpcc_datapath
  import cpcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_ctrl_t             ctrl_i,
  input  logic [15:0]          money_i,
  input  logic [15:0]          qty_i,
  input  logic [15:0]          price_i,
  output dp_stat_t             stat_o,
  output logic [15:0]          owe_o,
  output logic [15:0]          owe_next_o,
  output logic [DenBits-1:0]   den_o,
  output logic [CountBits-1:0] used_o,
  output logic [CountBits-1:0] dep_o
);

  logic [CountBits-1:0] stock_q [NumDen];
  logic [CountBits-1:0] dep_q   [NumDen];
  logic [CountBits-1:0] used_q  [NumDen];
  logic [PaidBits-1:0]  paid_q;
  logic [15:0]          price_q;
  logic                 open_q;
  logic [PaidBits-1:0]  left_q;
  logic [QuotBits-1:0]  quot_q;

  // Denomination decode of the inserted or loaded amount
  logic [IdxBits-1:0] midx;
  logic               mok;
  always_comb begin
    midx = '0;
    mok  = 1'b0;
    for (int i = 0; i < NumDen; i++) begin
      if ({3'b0, den_value(IdxBits'(i))} == money_i) begin
        midx = IdxBits'(i);
        mok  = 1'b1;
      end
    end
  end

  logic [IdxBits-1:0] ci;
  logic [DenBits-1:0] cden;
  assign ci   = ctrl_i.idx;
  assign cden = den_value(ci);

  // Quotient by reciprocal multiplication, registered before the take
  logic [LeftBits+RecipBits-1:0] quot_prod;
  assign quot_prod = (LeftBits+RecipBits)'(left_q[LeftBits-1:0]) *
                     (LeftBits+RecipBits)'(recip_value(ci));

  logic [CountBits-1:0] quot_ext;
  logic [CountBits-1:0] take;
  assign quot_ext = CountBits'(quot_q);
  assign take = (quot_ext < stock_q[ci]) ? quot_ext : stock_q[ci];

  logic [CountBits+DenBits-1:0] take_val;
  assign take_val = (CountBits+DenBits)'(take) * (CountBits+DenBits)'(cden);

  logic [PaidBits-1:0] paid_new;
  assign paid_new = paid_q + {{(PaidBits-DenBits){1'b0}}, den_value(midx)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDen; i++) begin
        stock_q[i] <= '0;
        dep_q[i]   <= '0;
        used_q[i]  <= '0;
      end
      paid_q  <= '0;
      price_q <= '0;
      open_q  <= 1'b0;
      left_q  <= '0;
      quot_q  <= '0;
    end else begin
      case (ctrl_i.cmd)
        CmdLoad: if (mok) stock_q[midx] <= qty_i;
        CmdBegin: begin
          price_q <= price_i;
          paid_q  <= '0;
          open_q  <= 1'b1;
        end
        CmdInsert: begin
          stock_q[midx] <= stock_q[midx] + 1'b1;
          dep_q[midx]   <= dep_q[midx] + 1'b1;
          paid_q        <= paid_new;
          left_q        <= paid_new - {1'b0, price_q};
        end
        CmdChgDiv: quot_q <= quot_prod[LeftBits+RecipBits-1:RecipShift];
        CmdChgTake: begin
          // Take as many pieces as are needed, up to what the stock holds
          used_q[ci]  <= take;
          stock_q[ci] <= stock_q[ci] - take;
          left_q      <= left_q - take_val[PaidBits-1:0];
        end
        CmdChgUndo: stock_q[ci] <= stock_q[ci] + used_q[ci];
        CmdRefStep: stock_q[ci] <= (stock_q[ci] >= dep_q[ci]) ?
                                   stock_q[ci] - dep_q[ci] : '0;
        CmdClose: begin
          for (int i = 0; i < NumDen; i++) begin
            dep_q[i]  <= '0;
            used_q[i] <= '0;
          end
          paid_q  <= '0;
          price_q <= '0;
          open_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.open       = open_q;
  assign stat_o.den_ok     = mok;
  assign stat_o.count_full = (stock_q[midx] == CountMax) || (dep_q[midx] == CountMax);
  assign stat_o.paid_ge    = paid_new >= {1'b0, price_q};
  assign stat_o.left_zero  = (left_q == '0);
  assign stat_o.used_nz    = (used_q[ci] != '0);
  assign stat_o.dep_nz     = (dep_q[ci] != '0);

  logic [PaidBits-1:0] owe, owe_next;
  assign owe        = {1'b0, price_q} - paid_q;
  assign owe_next   = {1'b0, price_q} - paid_new;
  assign owe_o      = owe[15:0];
  assign owe_next_o = owe_next[15:0];
  assign den_o  = cden;
  assign used_o = used_q[ci];
  assign dep_o  = dep_q[ci];

endmodule

@@ rtl/cpcc_control.sv @@
// Controller: sequences requests, change passes and refund passes; drives results.
module cpcc_control
  import cpcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [15:0]          price_i,
  output dp_ctrl_t             ctrl_o,
  input  dp_stat_t             stat_i,
  input  logic [15:0]          owe_i,
  input  logic [15:0]          owe_next_i,
  input  logic [DenBits-1:0]   den_i,
  input  logic [CountBits-1:0] used_i,
  input  logic [CountBits-1:0] dep_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [15:0]          remaining_o,
  output logic [DenBits-1:0]   den_o,
  output logic [15:0]          count_o,
  output logic                 last_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] STake  = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SUndo  = 3'd4;
  localparam logic [2:0] SEmit  = 3'd5;
  localparam logic [2:0] SRef   = 3'd6;
  localparam logic [2:0] SFinal = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [IdxBits-1:0] idx_q, idx_d;
  logic               sale_q, sale_d;
  logic               ov_q, ov_d;
  logic [2:0]         st_q, st_d;
  logic [15:0]        rm_q, rm_d;
  logic [DenBits-1:0] dn_q, dn_d;
  logic [15:0]        ct_q, ct_d;
  logic               ls_q, ls_d;
  logic               free;

  assign free       = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && free;

  // Next state, datapath command and result register load
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sale_d  = sale_q;
    ov_d    = ov_q && !out_ready_i;
    st_d    = st_q;
    rm_d    = rm_q;
    dn_d    = dn_q;
    ct_d    = ct_q;
    ls_d    = ls_q;
    ctrl_o.cmd = CmdNone;
    ctrl_o.idx = idx_q;
    unique case (state_q)
      SIdle: if (in_valid_i && free) begin
        ov_d = 1'b1; ls_d = 1'b1; rm_d = '0; dn_d = '0; ct_d = '0;
        st_d = StIgnored;
        unique case (func_i)
          FuncLoad: if (!stat_i.open) begin
            st_d = stat_i.den_ok ? StLoaded : StInvalid;
            ctrl_o.cmd = CmdLoad;
          end
          FuncBegin: if (!stat_i.open && price_i != '0) begin
            st_d = StNeedMore; rm_d = price_i; ctrl_o.cmd = CmdBegin;
          end
          FuncInsert: if (stat_i.open) begin
            if (!stat_i.den_ok || stat_i.count_full) begin
              st_d = StInvalid; rm_d = owe_i;
            end else begin
              ctrl_o.cmd = CmdInsert;
              if (!stat_i.paid_ge) begin
                st_d = StNeedMore; rm_d = owe_next_i;
              end else begin
                ov_d = 1'b0; idx_d = '0; state_d = SDiv;
              end
            end
          end
          FuncCancel: if (stat_i.open) begin
            ov_d = 1'b0; idx_d = '0; state_d = SRef;
          end
          default: ;
        endcase
      end
      SDiv: begin
        ctrl_o.cmd = CmdChgDiv;
        state_d = STake;
      end
      STake: begin
        ctrl_o.cmd = CmdChgTake;
        if (idx_q == IdxBits'(NumDen - 1)) begin
          idx_d = '0; state_d = SCheck;
        end else begin
          idx_d = idx_q + 1'b1; state_d = SDiv;
        end
      end
      // Exact change found: pay it out, else put the stock back
      SCheck: state_d = stat_i.left_zero ? SEmit : SUndo;
      SUndo: begin
        ctrl_o.cmd = CmdChgUndo;
        if (idx_q == IdxBits'(NumDen - 1)) begin
          idx_d = '0; state_d = SRef;
        end else idx_d = idx_q + 1'b1;
      end
      SEmit: if (free) begin
        if (stat_i.used_nz) begin
          ov_d = 1'b1; st_d = StChange; rm_d = '0; dn_d = den_i; ct_d = used_i;
          ls_d = 1'b0;
        end
        if (idx_q == IdxBits'(NumDen - 1)) begin
          state_d = SFinal; sale_d = 1'b1; idx_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      SRef: if (free) begin
        ctrl_o.cmd = CmdRefStep;
        if (stat_i.dep_nz) begin
          ov_d = 1'b1; st_d = StRefund; rm_d = '0; dn_d = den_i; ct_d = dep_i;
          ls_d = 1'b0;
        end
        if (idx_q == IdxBits'(NumDen - 1)) begin
          state_d = SFinal; sale_d = 1'b0; idx_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      SFinal: if (free) begin
        ctrl_o.cmd = CmdClose;
        ov_d = 1'b1; st_d = sale_q ? StSaleDone : StRefundDone;
        rm_d = '0; dn_d = '0; ct_d = '0; ls_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      sale_q  <= 1'b0;
      ov_q    <= 1'b0;
      st_q    <= '0;
      rm_q    <= '0;
      dn_q    <= '0;
      ct_q    <= '0;
      ls_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sale_q  <= sale_d;
      ov_q    <= ov_d;
      st_q    <= st_d;
      rm_q    <= rm_d;
      dn_q    <= dn_d;
      ct_q    <= ct_d;
      ls_q    <= ls_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign remaining_o = rm_q;
  assign den_o       = dn_q;
  assign count_o     = ct_q;
  assign last_o      = ls_q;

  // Result held steady while the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
    $stable({status_o, remaining_o, den_o, count_o, last_o}));
  // Requests are taken only between passes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == SIdle);
  // Denomination index stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IdxBits'(NumDen));

endmodule

@@ rtl/coin_purchase_change_controller.sv @@
// Top level: coin purchase change controller with stream request and result ports.
// One request is taken at a time. Loads, begins, ignored requests, invalid money and
// inserts that still owe money give one result and keep the controller idle, so the
// input is free again once the sink is ready for that result. A payment that completes
// a sale runs a change pass with, per denomination, a reciprocal multiply and then a
// take from stock, then a decision step, a pay-out per denomination and a final step.
// When exact change is impossible a restore per denomination comes before the refund
// pass. A cancel runs a refund per denomination and a final step. The pay-out, refund
// and final steps wait while a waiting result is stalled by the sink.
module coin_purchase_change_controller
  import cpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // [1:0] func, [17:2] money_cents, [33:18] quantity, [49:34] price_cents
  input  logic [55:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [2:0] status, [18:3] remaining_cents, [31:19] denom_value, [47:32] piece_count
  output logic [47:0] m_tdata_o,
  output logic        m_tlast_o
);

  dp_ctrl_t             ctrl;
  dp_stat_t             stat;
  logic [15:0]          owe, owe_next;
  logic [DenBits-1:0]   den;
  logic [CountBits-1:0] used, dep;
  logic [2:0]           st;
  logic [15:0]          rm, ct;
  logic [DenBits-1:0]   dn;

  cpcc_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .money_i(s_tdata_i[17:2]), .qty_i(s_tdata_i[33:18]), .price_i(s_tdata_i[49:34]),
    .stat_o(stat), .owe_o(owe), .owe_next_o(owe_next), .den_o(den), .used_o(used),
    .dep_o(dep)
  );

  cpcc_control u_ctl (
    .clk_i, .rst_ni, .in_valid_i(s_tvalid_i), .in_ready_o(s_tready_o),
    .func_i(s_tdata_i[1:0]), .price_i(s_tdata_i[49:34]), .ctrl_o(ctrl),
    .stat_i(stat), .owe_i(owe), .owe_next_i(owe_next), .den_i(den), .used_i(used),
    .dep_i(dep), .out_valid_o(m_tvalid_o), .out_ready_i(m_tready_i), .status_o(st),
    .remaining_o(rm), .den_o(dn), .count_o(ct), .last_o(m_tlast_o)
  );

  assign m_tdata_o = {ct, dn, rm, st};

endmodule

@@ tb/sv/cpcc_checker.sv @@
// Checker: watches both channels, predicts results of the change controller and compares.
`timescale 1ns / 100ps
module cpcc_checker
  import cpcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [1:0] func, [17:2] money_cents, [33:18] quantity, [49:34] price_cents
  input  logic [55:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [2:0] status, [18:3] remaining_cents, [31:19] denom_value, [47:32] piece_count
  input  logic [47:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        remaining;
    logic [DenBits-1:0] denom;
    logic [15:0]        pieces;
    logic               last;
  } result_t;

  result_t             owed_results[$];
  logic [CountBits:0]  stock_q[NumDen];
  logic [CountBits:0]  deposit_q[NumDen];
  logic [PaidBits-1:0] paid_q;
  logic [15:0]         price_q;
  logic                open_q;

  function automatic int den_index(input logic [15:0] cents);
    for (int i = 0; i < NumDen; i++) if (cents == 16'(den_value(IdxBits'(i)))) return i;
    return -1;
  endfunction

  function automatic void push_result(input logic [2:0] st, input logic [15:0] rem,
                                      input logic [DenBits-1:0] dv, input logic [15:0] pc);
    result_t r;
    r = '{st, rem, dv, pc, 1'b0};
    owed_results.push_back(r);
  endfunction

  function automatic void close_sale();
    for (int i = 0; i < NumDen; i++) deposit_q[i] = '0;
    paid_q  = '0;
    price_q = '0;
    open_q  = 1'b0;
  endfunction

  function automatic void refund_all();
    for (int i = 0; i < NumDen; i++) begin
      stock_q[i] = (stock_q[i] >= deposit_q[i]) ? stock_q[i] - deposit_q[i] : '0;
      if (deposit_q[i] != 0)
        push_result(StRefund, '0, den_value(IdxBits'(i)), 16'(deposit_q[i]));
    end
    close_sale();
    push_result(StRefundDone, '0, '0, '0);
  endfunction

  function automatic void pay_change(input int unsigned change);
    int unsigned used[NumDen];
    int unsigned left, need, take, dv;
    left = change;
    for (int i = 0; i < NumDen; i++) begin
      dv   = den_value(IdxBits'(i));
      need = left / dv;
      take = (need < stock_q[i]) ? need : stock_q[i];
      used[i] = take;
      stock_q[i] = stock_q[i] - take;
      left = left - take * dv;
    end
    if (left != 0) begin
      for (int i = 0; i < NumDen; i++) stock_q[i] = stock_q[i] + used[i];
      refund_all();
    end else begin
      for (int i = 0; i < NumDen; i++)
        if (used[i] != 0) push_result(StChange, '0, den_value(IdxBits'(i)), 16'(used[i]));
      close_sale();
      push_result(StSaleDone, '0, '0, '0);
    end
  endfunction

  // Work out every result that one request causes
  function automatic void predict_request(input logic [55:0] d);
    logic [1:0]  fn;
    logic [15:0] money, qty, price;
    int          idx;
    fn = d[1:0]; money = d[17:2]; qty = d[33:18]; price = d[49:34];
    idx = den_index(money);
    case (fn)
      FuncLoad: begin
        if (open_q) push_result(StIgnored, '0, '0, '0);
        else if (idx < 0) push_result(StInvalid, '0, '0, '0);
        else begin
          stock_q[idx] = {1'b0, qty};
          push_result(StLoaded, '0, '0, '0);
        end
      end
      FuncBegin: begin
        if (open_q || price == 0) push_result(StIgnored, '0, '0, '0);
        else begin
          close_sale();
          price_q = price;
          open_q  = 1'b1;
          push_result(StNeedMore, price, '0, '0);
        end
      end
      FuncInsert: begin
        if (!open_q) push_result(StIgnored, '0, '0, '0);
        else if (idx < 0 || stock_q[idx] >= CountMax || deposit_q[idx] >= CountMax)
          push_result(StInvalid, 16'(price_q - paid_q), '0, '0);
        else begin
          stock_q[idx]++;
          deposit_q[idx]++;
          paid_q = paid_q + den_value(IdxBits'(idx));
          if (paid_q < price_q) push_result(StNeedMore, 16'(price_q - paid_q), '0, '0);
          else pay_change(paid_q - price_q);
        end
      end
      default: begin
        if (!open_q) push_result(StIgnored, '0, '0, '0);
        else refund_all();
      end
    endcase
    owed_results[$].last = 1'b1;
  endfunction

  // Predict on accepted requests, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < NumDen; i++) begin
        stock_q[i] = '0;
        deposit_q[i] = '0;
      end
      paid_q = '0; price_q = '0; open_q = 1'b0;
      fail_count_o = 0;
      owed_results.delete();
      pending_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{m_tdata_i[2:0], m_tdata_i[18:3], m_tdata_i[31:19], m_tdata_i[47:32],
                m_tlast_i};
        if (owed_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %h", got);
        end else begin
          want = owed_results.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch: exp st=%0d rem=%0d den=%0d pcs=%0d last=%0d, ",
                        "got st=%0d rem=%0d den=%0d pcs=%0d last=%0d"},
                       want.status, want.remaining, want.denom, want.pieces, want.last,
                       got.status, got.remaining, got.denom, got.pieces, got.last);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) predict_request(s_tdata_i);
      pending_o = owed_results.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: request stimulus, result back-pressure and the verdict.
`timescale 1ns / 100ps
module testbench
  import cpcc_pkg::*;
();

  logic        clk_i, rst_ni;
  logic        s_tvalid_i, s_tready_o, m_tvalid_o, m_tready_i, m_tlast_o;
  logic [55:0] s_tdata_i;
  logic [47:0] m_tdata_o;
  int          fail_count, pending, send_idle_pct, recv_stall_pct;
  int          hold_cycles;
  longint      cycle_count;

  coin_purchase_change_controller i_dut (.*);

  cpcc_checker i_checker (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tlast_i(m_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Timeout guard
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off counted here
  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready_i <= 1'b0;
      end else m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [15:0] pick_den();
    return 16'(den_value(IdxBits'($urandom_range(NumDen - 1))));
  endfunction

  function automatic logic [15:0] pick_money();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      default: return pick_den();
    endcase
  endfunction

  // Valid stays high into the next request unless an idle gap is drawn
  task automatic send(input logic [1:0] fn, input logic [15:0] money,
                      input logic [15:0] qty, input logic [15:0] price);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'b0, price, qty, money, fn};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  // Random mix biased towards well-formed purchases
  task automatic random_phase(input int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin send(FuncLoad, pick_money(), 16'($urandom), '0); k++; end
        1: begin send(FuncLoad, pick_den(), 16'($urandom_range(5)), '0); k++; end
        2: begin send(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)); k++; end
        default: begin
          send(FuncBegin, '0, '0, ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1, 3000)));
          k++;
          repeat ($urandom_range(1, 6)) begin
            send(($urandom_range(15) == 0) ? FuncCancel : FuncInsert, pick_money(), '0, '0);
            k++;
          end
        end
      endcase
    end
  endtask

  initial begin
    s_tvalid_i = 1'b0; s_tdata_i = '0; rst_ni = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: ignored requests with nothing open, loads, invalid money
    send(FuncInsert, 16'd100, '0, '0);
    send(FuncCancel, '0, '0, '0);
    send(FuncBegin, '0, '0, '0);
    send(FuncLoad, 16'd7, 16'd3, '0);
    send(FuncLoad, 16'd5000, 16'hFFFF, '0);
    send(FuncLoad, 16'd5, 16'hFFFF, '0);
    send(FuncLoad, 16'd100, 16'd0, '0);
    send(FuncLoad, 16'd500, 16'd4, '0);
    send(FuncLoad, 16'd20, 16'd10, '0);
    // Purchase opened, with ignored load and begin and rejected money during purchase
    send(FuncBegin, '0, '0, 16'd500);
    send(FuncLoad, 16'd500, 16'd1, '0);
    send(FuncBegin, '0, '0, 16'd9);
    send(FuncInsert, 16'd3, '0, '0);
    send(FuncInsert, 16'd5000, '0, '0);
    send(FuncBegin, '0, '0, 16'd700);
    // Full stock: insert rejected; then change paid
    send(FuncInsert, 16'd5, '0, '0);
    send(FuncInsert, 16'd1000, '0, '0);
    // Change impossible and cancel
    send(FuncBegin, '0, '0, 16'd1);
    send(FuncInsert, 16'd10, '0, '0);
    send(FuncBegin, '0, '0, 16'hFFFF);
    send(FuncInsert, 16'd50, '0, '0);
    send(FuncInsert, 16'd200, '0, '0);
    send(FuncCancel, '0, '0, '0);
    send(FuncBegin, '0, '0, 16'd1);
    send(FuncInsert, 16'd5000, '0, '0);
    // Random phases across the idling settings
    random_phase(110);
    send_idle_pct = 54;
    random_phase(110);
    send_idle_pct = 0; recv_stall_pct = 54;
    hold_cycles = 600;
    random_phase(110);
    send_idle_pct = 35; recv_stall_pct = 35;
    random_phase(110);
    s_tvalid_i <= 1'b0;
    wait_idle();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
